// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the modexp rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define MODEXP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("modexp same-cycle check failed");
// next-cycle implication, checked out of reset
`define MODEXP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("modexp next-cycle check failed");
`else
`define MODEXP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MODEXP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/modexp_pkg.sv -----
package modexp_pkg;

  // operand width of the datapath
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS + 1);
  localparam int PC_W      = 5;

  // datapath operations driven by the control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LD_BASE,
    OP_DBL,
    OP_ADD,
    OP_SET_BASE,
    OP_LD_SQ,
    OP_ST_RES,
    OP_LD_MB,
    OP_SET_ONE,
    OP_SET_ERR,
    OP_EMIT
  } op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_FIRE,
    C_EXP_ZERO,
    C_MOD_ZERO,
    C_CNT_MORE,
    C_EBIT_CLR,
    C_ECNT_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic exp_zero;
    logic mod_zero;
    logic cnt_more;
    logic ebit_clr;
    logic ecnt_more;
    logic out_busy;
  } dp_stat_t;

  // program addresses
  localparam logic [PC_W-1:0] ST_WAIT  = PC_W'(0);
  localparam logic [PC_W-1:0] ST_CHKE  = PC_W'(1);
  localparam logic [PC_W-1:0] ST_CHKM  = PC_W'(2);
  localparam logic [PC_W-1:0] ST_LDB   = PC_W'(3);
  localparam logic [PC_W-1:0] ST_RDBL  = PC_W'(4);
  localparam logic [PC_W-1:0] ST_RADD  = PC_W'(5);
  localparam logic [PC_W-1:0] ST_SETB  = PC_W'(6);
  localparam logic [PC_W-1:0] ST_LDSQ  = PC_W'(7);
  localparam logic [PC_W-1:0] ST_SDBL  = PC_W'(8);
  localparam logic [PC_W-1:0] ST_SADD  = PC_W'(9);
  localparam logic [PC_W-1:0] ST_STSQ  = PC_W'(10);
  localparam logic [PC_W-1:0] ST_LDMB  = PC_W'(11);
  localparam logic [PC_W-1:0] ST_MDBL  = PC_W'(12);
  localparam logic [PC_W-1:0] ST_MADD  = PC_W'(13);
  localparam logic [PC_W-1:0] ST_STMB  = PC_W'(14);
  localparam logic [PC_W-1:0] ST_ELOOP = PC_W'(15);
  localparam logic [PC_W-1:0] ST_EMIT  = PC_W'(16);
  localparam logic [PC_W-1:0] ST_BACK  = PC_W'(17);
  localparam logic [PC_W-1:0] ST_ONE   = PC_W'(18);
  localparam logic [PC_W-1:0] ST_ERR   = PC_W'(19);
  localparam logic [PC_W-1:0] ST_LAST  = ST_ERR;

  // microcode rom
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: ST_WAIT};
    unique case (pc)
      ST_WAIT:  w = '{op: OP_LOAD,     cond: C_NO_FIRE,   target: ST_WAIT};
      ST_CHKE:  w = '{op: OP_NONE,     cond: C_EXP_ZERO,  target: ST_ONE};
      ST_CHKM:  w = '{op: OP_NONE,     cond: C_MOD_ZERO,  target: ST_ERR};
      ST_LDB:   w = '{op: OP_LD_BASE,  cond: C_NEVER,     target: ST_WAIT};
      ST_RDBL:  w = '{op: OP_DBL,      cond: C_NEVER,     target: ST_WAIT};
      ST_RADD:  w = '{op: OP_ADD,      cond: C_CNT_MORE,  target: ST_RDBL};
      ST_SETB:  w = '{op: OP_SET_BASE, cond: C_NEVER,     target: ST_WAIT};
      ST_LDSQ:  w = '{op: OP_LD_SQ,    cond: C_NEVER,     target: ST_WAIT};
      ST_SDBL:  w = '{op: OP_DBL,      cond: C_NEVER,     target: ST_WAIT};
      ST_SADD:  w = '{op: OP_ADD,      cond: C_CNT_MORE,  target: ST_SDBL};
      ST_STSQ:  w = '{op: OP_ST_RES,   cond: C_EBIT_CLR,  target: ST_ELOOP};
      ST_LDMB:  w = '{op: OP_LD_MB,    cond: C_NEVER,     target: ST_WAIT};
      ST_MDBL:  w = '{op: OP_DBL,      cond: C_NEVER,     target: ST_WAIT};
      ST_MADD:  w = '{op: OP_ADD,      cond: C_CNT_MORE,  target: ST_MDBL};
      ST_STMB:  w = '{op: OP_ST_RES,   cond: C_NEVER,     target: ST_WAIT};
      ST_ELOOP: w = '{op: OP_NONE,     cond: C_ECNT_MORE, target: ST_LDSQ};
      ST_EMIT:  w = '{op: OP_EMIT,     cond: C_OUT_BUSY,  target: ST_EMIT};
      ST_BACK:  w = '{op: OP_NONE,     cond: C_ALWAYS,    target: ST_WAIT};
      ST_ONE:   w = '{op: OP_SET_ONE,  cond: C_ALWAYS,    target: ST_EMIT};
      ST_ERR:   w = '{op: OP_SET_ERR,  cond: C_ALWAYS,    target: ST_EMIT};
      default:  w = '{op: OP_NONE,     cond: C_ALWAYS,    target: ST_WAIT};
    endcase
    return w;
  endfunction

  // (x + y) mod m for x, y below m
  function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] x,
                                                   input logic [WORD_BITS-1:0] y,
                                                   input logic [WORD_BITS-1:0] m);
    logic [WORD_BITS:0] s;
    logic [WORD_BITS:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, m};
    return (s >= {1'b0, m}) ? d[WORD_BITS-1:0] : s[WORD_BITS-1:0];
  endfunction

endpackage

// ----- rtl/modular_exponentiation.sv -----
// channel | beat fields                              | handshake
// in      | base_value[31:0] exponent[31:0] modulus  | in_valid / in_ready
// out     | result[31:0] error                       | out_valid / out_ready
//
// multiply: the shared shift-and-add modular multiplier runs a doubling step
//   and an add step for each multiplier bit
// a zero exponent goes straight to a result of one, a zero modulus to an error
// reset: synchronous, active low; clears the step counter and the output valid
// stalls: a finished result waits in the output register; the next item is
//   taken while it waits, and only the final write waits for the slot to free

module modular_exponentiation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_base_value,
  input  logic [31:0] in_exponent,
  input  logic [31:0] in_modulus,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result,
  output logic        out_error
);

  // the microcode word drives the datapath; the datapath reports its flags back
  modexp_pkg::ctrl_t    ctrl;
  modexp_pkg::dp_stat_t stat;
  logic                 in_fire;

  // a beat is taken only while the sequencer sits on its wait step
  assign in_fire = in_valid && in_ready;

  // step counter, microcode rom and jump logic
  modexp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  // operand registers, modular add unit and output register
  modexp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_fire       (in_fire),
    .in_base_value (in_base_value),
    .in_exponent   (in_exponent),
    .in_modulus    (in_modulus),
    .out_ready     (out_ready),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_result    (out_result),
    .out_error     (out_error)
  );

endmodule

// ----- rtl/modexp_seq.sv -----
`include "assert_macros.svh"

module modexp_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_fire,
  input  modexp_pkg::dp_stat_t     stat,
  output modexp_pkg::ctrl_t        ctrl,
  output logic                     in_ready
);

  logic [modexp_pkg::PC_W-1:0] pc_r;
  logic [modexp_pkg::PC_W-1:0] pc_nxt;
  logic                        take;

  assign ctrl     = modexp_pkg::ucode(pc_r);
  assign in_ready = (pc_r == modexp_pkg::ST_WAIT);

  always_comb begin
    unique case (ctrl.cond)
      modexp_pkg::C_NEVER:     take = 1'b0;
      modexp_pkg::C_ALWAYS:    take = 1'b1;
      modexp_pkg::C_NO_FIRE:   take = !in_fire;
      modexp_pkg::C_EXP_ZERO:  take = stat.exp_zero;
      modexp_pkg::C_MOD_ZERO:  take = stat.mod_zero;
      modexp_pkg::C_CNT_MORE:  take = stat.cnt_more;
      modexp_pkg::C_EBIT_CLR:  take = stat.ebit_clr;
      modexp_pkg::C_ECNT_MORE: take = stat.ecnt_more;
      modexp_pkg::C_OUT_BUSY:  take = stat.out_busy;
      default:                 take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + modexp_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= modexp_pkg::ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  `MODEXP_ASSERT_IMP(a_pc_range, clk, rst_n, 1'b1, pc_r <= modexp_pkg::ST_LAST)
  `MODEXP_ASSERT_NXT(a_fire_to_check, clk, rst_n, in_fire, pc_r == modexp_pkg::ST_CHKE)
  `MODEXP_ASSERT_IMP(a_ready_load, clk, rst_n, in_ready, ctrl.op == modexp_pkg::OP_LOAD)

endmodule

// ----- rtl/modexp_dp.sv -----
`include "assert_macros.svh"

module modexp_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  modexp_pkg::ctrl_t     ctrl,
  input  logic                  in_fire,
  input  logic [31:0]           in_base_value,
  input  logic [31:0]           in_exponent,
  input  logic [31:0]           in_modulus,
  input  logic                  out_ready,
  output modexp_pkg::dp_stat_t  stat,
  output logic                  out_valid,
  output logic [31:0]           out_result,
  output logic                  out_error
);

  localparam int W  = modexp_pkg::WORD_BITS;
  localparam int CW = modexp_pkg::CNT_W;

  logic [W-1:0]  exp_r, exp_nxt;
  logic [W-1:0]  mod_r, mod_nxt;
  logic [W-1:0]  bval_r, bval_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  opa_r, opa_nxt;
  logic [W-1:0]  mlt_r, mlt_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ecnt_r, ecnt_nxt;
  logic          ebit_r, ebit_nxt;
  logic          addf_r, addf_nxt;
  logic          err_r, err_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_result_r, out_result_nxt;
  logic          out_error_r, out_error_nxt;

  // port width to operand width and back, for any operand width
  logic [W+31:0] b_ext, e_ext, m_ext, r_ext;
  assign b_ext = {{W{1'b0}}, in_base_value};
  assign e_ext = {{W{1'b0}}, in_exponent};
  assign m_ext = {{W{1'b0}}, in_modulus};
  assign r_ext = {32'd0, res_r};

  logic out_busy;
  assign out_busy = out_valid_r && !out_ready;

  assign stat.exp_zero  = (exp_r == '0);
  assign stat.mod_zero  = (mod_r == '0);
  assign stat.cnt_more  = (cnt_r != '0);
  assign stat.ebit_clr  = !ebit_r;
  assign stat.ecnt_more = (ecnt_r != '0);
  assign stat.out_busy  = out_busy;

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_error  = out_error_r;

  always_comb begin
    exp_nxt        = exp_r;
    mod_nxt        = mod_r;
    bval_nxt       = bval_r;
    res_nxt        = res_r;
    acc_nxt        = acc_r;
    opa_nxt        = opa_r;
    mlt_nxt        = mlt_r;
    cnt_nxt        = cnt_r;
    ecnt_nxt       = ecnt_r;
    ebit_nxt       = ebit_r;
    addf_nxt       = addf_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_result_nxt = out_result_r;
    out_error_nxt  = out_error_r;
    unique case (ctrl.op)
      modexp_pkg::OP_NONE: begin
      end
      modexp_pkg::OP_LOAD: begin
        if (in_fire) begin
          bval_nxt = b_ext[W-1:0];
          exp_nxt  = e_ext[W-1:0];
          mod_nxt  = m_ext[W-1:0];
          err_nxt  = 1'b0;
        end
      end
      modexp_pkg::OP_LD_BASE: begin
        // base mod m as 1 * base
        acc_nxt = '0;
        opa_nxt = W'(1);
        mlt_nxt = bval_r;
        cnt_nxt = CW'(W);
      end
      modexp_pkg::OP_DBL: begin
        acc_nxt  = modexp_pkg::add_mod(acc_r, acc_r, mod_r);
        addf_nxt = mlt_r[W-1];
        mlt_nxt  = {mlt_r[W-2:0], 1'b0};
        cnt_nxt  = cnt_r - CW'(1);
      end
      modexp_pkg::OP_ADD: begin
        if (addf_r) begin
          acc_nxt = modexp_pkg::add_mod(acc_r, opa_r, mod_r);
        end
      end
      modexp_pkg::OP_SET_BASE: begin
        bval_nxt = acc_r;
        res_nxt  = (mod_r == W'(1)) ? '0 : W'(1);
        ecnt_nxt = CW'(W);
      end
      modexp_pkg::OP_LD_SQ: begin
        acc_nxt  = '0;
        opa_nxt  = res_r;
        mlt_nxt  = res_r;
        cnt_nxt  = CW'(W);
        ebit_nxt = exp_r[W-1];
        exp_nxt  = {exp_r[W-2:0], 1'b0};
        ecnt_nxt = ecnt_r - CW'(1);
      end
      modexp_pkg::OP_ST_RES: begin
        res_nxt = acc_r;
      end
      modexp_pkg::OP_LD_MB: begin
        acc_nxt = '0;
        opa_nxt = res_r;
        mlt_nxt = bval_r;
        cnt_nxt = CW'(W);
      end
      modexp_pkg::OP_SET_ONE: begin
        res_nxt = W'(1);
        err_nxt = 1'b0;
      end
      modexp_pkg::OP_SET_ERR: begin
        res_nxt = '0;
        err_nxt = 1'b1;
      end
      modexp_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = r_ext[31:0];
          out_error_nxt  = err_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exp_r        <= exp_nxt;
    mod_r        <= mod_nxt;
    bval_r       <= bval_nxt;
    res_r        <= res_nxt;
    acc_r        <= acc_nxt;
    opa_r        <= opa_nxt;
    mlt_r        <= mlt_nxt;
    cnt_r        <= cnt_nxt;
    ecnt_r       <= ecnt_nxt;
    ebit_r       <= ebit_nxt;
    addf_r       <= addf_nxt;
    err_r        <= err_nxt;
    out_result_r <= out_result_nxt;
    out_error_r  <= out_error_nxt;
  end

  // a shift-and-add step of the modular multiplier is running
  logic mul_step;
  assign mul_step = (ctrl.op == modexp_pkg::OP_DBL) || (ctrl.op == modexp_pkg::OP_ADD);

  `MODEXP_ASSERT_IMP(a_acc_reduced, clk, rst_n, mul_step, acc_r < mod_r)
  `MODEXP_ASSERT_IMP(a_res_reduced, clk, rst_n, ctrl.op == modexp_pkg::OP_LD_SQ, res_r < mod_r)
  `MODEXP_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid_r && out_error_r, out_result_r == '0)

endmodule
